[src/fcsr_pkg.sv]
// shared types and constants for the filled circle span rasterizer
`timescale 1ns / 1ps

package fcsr_pkg;

    localparam int CFG_W   = 13;  // configuration register width
    localparam int IN_W    = 13;  // centre coordinate width
    localparam int RAD_W   = 5;   // radius width
    localparam int COLOR_W = 32;  // colour word width
    localparam int ADDR_W  = 24;  // frame buffer word address width
    localparam int CALC_W  = 18;  // signed working width for rows and columns
    localparam int SQ_W    = 10;  // radius squared
    localparam int ROOT_W  = 11;  // square root trial terms

    // highest power of four not above the largest radicand (31*31)
    localparam logic [ROOT_W-1:0] ROOT_BIT_INIT = 11'd256;

    typedef enum logic [1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_LINE_PITCH    = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ROW,
        ST_ROOT,
        ST_CLIP,
        ST_ADDR,
        ST_EMIT
    } t_state;

endpackage

[src/filled_circle_span_rasterizer_top.sv]
// filled circle span rasterizer: one clipped span per visible circle row
`timescale 1ns / 1ps

// sequence: a taken circle gets a setup step, then each row gets a radicand step, 5 square root
// steps, a clip and multiply step, an address add step and an emit step; a circle with no
// visible row goes from setup straight to its marker
// flow: one circle at a time, the input stalls until its last span or marker is accepted
// the span rate is set by the shared bit-serial square root unit, one step a cycle
// reset: synchronous active low, sequencer to idle, registers to 1920/1080/1920

module filled_circle_span_rasterizer_top
    import fcsr_pkg::*;
#(
    parameter int MAX_RADIUS = 31,
    parameter int COORD_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    // circle input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [IN_W-1:0]   i_center_x,
    input  logic signed [IN_W-1:0]   i_center_y,
    input  logic [RAD_W-1:0]         i_radius,
    input  logic [COLOR_W-1:0]       i_fill_color,
    // span output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [COORD_BITS-1:0]    o_row_y,
    output logic [COORD_BITS-1:0]    o_span_x_first,
    output logic [COORD_BITS-1:0]    o_span_x_final,
    output logic [ADDR_W-1:0]        o_span_word_address,
    output logic [COLOR_W-1:0]       o_span_color,
    output logic                     o_span_empty,
    output logic                     o_nothing_drawn,
    output logic                     o_last_span
);

    // product of a row and the line pitch, and the width of the address sum
    localparam int PROD_W = COORD_BITS + CFG_W;
    localparam int SUM_W  = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

    // width and height beyond the coordinate range act as the range itself
    localparam logic signed [CALC_W-1:0] DIM_LIMIT = CALC_W'(1) <<< COORD_BITS;
    localparam logic [RAD_W-1:0]         RAD_MAX   = RAD_W'(MAX_RADIUS);

    // configuration registers
    logic [CFG_W-1:0] r_screen_width;
    logic [CFG_W-1:0] r_screen_height;
    logic [CFG_W-1:0] r_line_pitch;

    // sequencer and working registers
    t_state                     r_state, n_state;
    logic signed [IN_W-1:0]     r_cx, n_cx;
    logic signed [IN_W-1:0]     r_cy, n_cy;
    logic [RAD_W-1:0]           r_rad, n_rad;
    logic [COLOR_W-1:0]         r_color, n_color;
    logic [SQ_W-1:0]            r_rr, n_rr;        // saturated radius squared
    logic signed [CALC_W-1:0]   r_y, n_y;          // current row offset
    logic signed [CALC_W-1:0]   r_y_hi, n_y_hi;    // last visible row offset
    logic [SQ_W-1:0]            r_rem, n_rem;      // square root remainder
    logic [ROOT_W-1:0]          r_root, n_root;
    logic [ROOT_W-1:0]          r_bit, n_bit;
    logic [PROD_W-1:0]          r_prod, n_prod;

    // result payload, held steady while the output is stalled
    logic [COORD_BITS-1:0]      r_row, n_row;
    logic [COORD_BITS-1:0]      r_first, n_first;
    logic [COORD_BITS-1:0]      r_last, n_last;
    logic [ADDR_W-1:0]          r_addr, n_addr;
    logic                       r_empty, n_empty;
    logic                       r_nothing, n_nothing;
    logic                       r_last_span, n_last_span;

    // combinational helpers
    logic signed [CALC_W-1:0]   w_eff, h_eff, cx_ext, cy_ext, rad_ext;
    logic signed [CALC_W-1:0]   y_lo, y_top, y_abs, half, col_lo, col_hi, row_s;
    logic [RAD_W-1:0]           rad_sat;
    logic [SQ_W-1:0]            ysq;
    logic [ROOT_W-1:0]          trial;
    logic                       span_gone;
    logic [SUM_W-1:0]           addr_sum;

    // configuration writes: taken whenever the enable is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= CFG_W'(1920);
            r_screen_height <= CFG_W'(1080);
            r_line_pitch    <= CFG_W'(1920);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                REG_LINE_PITCH:    r_line_pitch    <= i_cfg_data;
                default: ;  // index beyond the register list is dropped
            endcase
        end
    end

    // state register; payload and working registers need no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx        <= n_cx;
        r_cy        <= n_cy;
        r_rad       <= n_rad;
        r_color     <= n_color;
        r_rr        <= n_rr;
        r_y         <= n_y;
        r_y_hi      <= n_y_hi;
        r_rem       <= n_rem;
        r_root      <= n_root;
        r_bit       <= n_bit;
        r_prod      <= n_prod;
        r_row       <= n_row;
        r_first     <= n_first;
        r_last      <= n_last;
        r_addr      <= n_addr;
        r_empty     <= n_empty;
        r_nothing   <= n_nothing;
        r_last_span <= n_last_span;
    end

    // clamped screen size and sign-extended centre
    always_comb begin
        w_eff = signed'(CALC_W'(r_screen_width));
        if (w_eff > DIM_LIMIT) begin
            w_eff = DIM_LIMIT;
        end
        h_eff = signed'(CALC_W'(r_screen_height));
        if (h_eff > DIM_LIMIT) begin
            h_eff = DIM_LIMIT;
        end
        cx_ext = CALC_W'(r_cx);
        cy_ext = CALC_W'(r_cy);
    end

    // visible row offsets form one interval: max(-r, -cy) .. min(r, h-1-cy)
    always_comb begin
        rad_sat = (r_rad > RAD_MAX) ? RAD_MAX : r_rad;
        rad_ext = signed'({{(CALC_W-RAD_W){1'b0}}, rad_sat});
        y_lo    = (-rad_ext > -cy_ext) ? -rad_ext : -cy_ext;
        y_top   = (rad_ext < h_eff - CALC_W'(1) - cy_ext) ?
                  rad_ext : h_eff - CALC_W'(1) - cy_ext;
    end

    // radicand for the current row: r*r - y*y, |y| never exceeds r
    always_comb begin
        y_abs = r_y[CALC_W-1] ? -r_y : r_y;
        ysq   = SQ_W'(y_abs[RAD_W-1:0]) * SQ_W'(y_abs[RAD_W-1:0]);
    end

    // shared square root step: one restoring trial per cycle
    assign trial = r_root + r_bit;

    // horizontal clip of the span around the centre
    always_comb begin
        half   = signed'({{(CALC_W-RAD_W){1'b0}}, r_root[RAD_W-1:0]});
        col_lo = cx_ext - half;
        col_hi = cx_ext + half;
        if (col_lo < 0) begin
            col_lo = '0;
        end
        if (col_hi > w_eff - CALC_W'(1)) begin
            col_hi = w_eff - CALC_W'(1);
        end
        span_gone = (col_lo > col_hi);
        row_s     = cy_ext + r_y;
    end

    // word address wraps to the address width
    assign addr_sum = SUM_W'(r_prod) + SUM_W'(r_first);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_rad       = r_rad;
        n_color     = r_color;
        n_rr        = r_rr;
        n_y         = r_y;
        n_y_hi      = r_y_hi;
        n_rem       = r_rem;
        n_root      = r_root;
        n_bit       = r_bit;
        n_prod      = r_prod;
        n_row       = r_row;
        n_first     = r_first;
        n_last      = r_last;
        n_addr      = r_addr;
        n_empty     = r_empty;
        n_nothing   = r_nothing;
        n_last_span = r_last_span;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_cx    = i_center_x;
                    n_cy    = i_center_y;
                    n_rad   = i_radius;
                    n_color = i_fill_color;
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_rr   = SQ_W'(rad_sat) * SQ_W'(rad_sat);
                n_y    = y_lo;
                n_y_hi = y_top;
                if (y_lo > y_top) begin
                    // no visible row: a single marker transaction
                    n_row       = '0;
                    n_first     = '0;
                    n_last      = '0;
                    n_addr      = '0;
                    n_empty     = 1'b0;
                    n_nothing   = 1'b1;
                    n_last_span = 1'b1;
                    n_state     = ST_EMIT;
                end else begin
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                n_rem   = r_rr - ysq;
                n_root  = '0;
                n_bit   = ROOT_BIT_INIT;
                n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (ROOT_W'(r_rem) >= trial) begin
                    n_rem  = r_rem - SQ_W'(trial);
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit == ROOT_W'(1)) begin
                    n_state = ST_CLIP;
                end
            end
            ST_CLIP: begin
                n_row       = row_s[COORD_BITS-1:0];
                n_first     = span_gone ? '0 : col_lo[COORD_BITS-1:0];
                n_last      = span_gone ? '0 : col_hi[COORD_BITS-1:0];
                n_empty     = span_gone;
                n_nothing   = 1'b0;
                n_last_span = (r_y == r_y_hi);
                n_prod      = PROD_W'(row_s[COORD_BITS-1:0]) * PROD_W'(r_line_pitch);
                n_state     = ST_ADDR;
            end
            ST_ADDR: begin
                n_addr  = addr_sum[ADDR_W-1:0];
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_stall) begin
                    if (r_last_span) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_y     = r_y + CALC_W'(1);
                        n_state = ST_ROW;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // handshakes: one circle in flight, the result waits in the payload registers
    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_EMIT);

    assign o_row_y             = r_row;
    assign o_span_x_first      = r_first;
    assign o_span_x_final      = r_last;
    assign o_span_word_address = r_addr;
    assign o_span_color        = r_color;
    assign o_span_empty        = r_empty;
    assign o_nothing_drawn     = r_nothing;
    assign o_last_span         = r_last_span;

endmodule

[src/fcsr_checker.sv]
// port-level checks for the filled circle span rasterizer, bound to the top level
`timescale 1ns / 1ps

module fcsr_checker
    import fcsr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    input  logic                     o_stall,
    input  logic signed [IN_W-1:0]   i_center_x,
    input  logic signed [IN_W-1:0]   i_center_y,
    input  logic [RAD_W-1:0]         i_radius,
    input  logic [COLOR_W-1:0]       i_fill_color,
    input  logic                     o_valid,
    input  logic                     i_stall,
    input  logic [COORD_BITS-1:0]    o_row_y,
    input  logic [COORD_BITS-1:0]    o_span_x_first,
    input  logic [COORD_BITS-1:0]    o_span_x_final,
    input  logic [ADDR_W-1:0]        o_span_word_address,
    input  logic [COLOR_W-1:0]       o_span_color,
    input  logic                     o_span_empty,
    input  logic                     o_nothing_drawn,
    input  logic                     o_last_span
);

    // a stalled transaction keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_row_y) && $stable(o_span_x_first)
            && $stable(o_span_x_final) && $stable(o_span_word_address)
            && $stable(o_span_color) && $stable(o_span_empty)
            && $stable(o_nothing_drawn) && $stable(o_last_span))
        else $error("stalled span changed");

    // an accepted circle blocks the input: the stall is high once it is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken again while a circle is in flight");

    // the nothing drawn marker is the final transaction, not empty, with row and address zero
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_nothing_drawn |-> o_last_span && !o_span_empty
            && o_row_y == '0 && o_span_word_address == '0)
        else $error("malformed nothing drawn marker");

    // a drawn span runs left to right
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_span_empty && !o_nothing_drawn |-> o_span_x_first <= o_span_x_final)
        else $error("span ends before it starts");

    // an empty span reports both columns as zero
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_span_empty |-> o_span_x_first == '0 && o_span_x_final == '0)
        else $error("empty span with nonzero columns");

endmodule

bind filled_circle_span_rasterizer_top fcsr_checker #(.COORD_BITS(COORD_BITS)) u_fcsr_checker (.*);

[test/filled_circle_span_rasterizer_top_test.sv]
// self-checking testbench for the filled circle span rasterizer top level
`timescale 1ns / 1ps

module filled_circle_span_rasterizer_top_test
    import fcsr_pkg::*;
;

    localparam int MAX_RADIUS   = 31;
    localparam int COORD_BITS   = 12;
    localparam int DIM_LIMIT    = 1 << COORD_BITS;    // larger width or height acts as this
    localparam int IDLE_PERCENT = 26;
    localparam int SETTLE_CYCLES = 20;                // quiet time before a register write
    localparam int TAIL_CYCLES   = 100;               // watch for stray spans at the end
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int REPORT_LIMIT  = 200;               // keeps a broken run readable

    // one circle as it goes into the block
    typedef struct packed {
        logic [IN_W-1:0]    cx;
        logic [IN_W-1:0]    cy;
        logic [RAD_W-1:0]   radius;
        logic [COLOR_W-1:0] color;
    } t_circle;

    // one span as it should come out
    typedef struct packed {
        logic [COORD_BITS-1:0] row_y;
        logic [COORD_BITS-1:0] x_first;
        logic [COORD_BITS-1:0] x_final;
        logic [ADDR_W-1:0]     addr;
        logic [COLOR_W-1:0]    color;
        logic                  empty;
        logic                  none;
        logic                  last;
    } t_span;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  circle_valid = 1'b0;
    logic                  circle_stall;
    logic [IN_W-1:0]       center_x = '0;
    logic [IN_W-1:0]       center_y = '0;
    logic [RAD_W-1:0]      radius = '0;
    logic [COLOR_W-1:0]    fill_color = '0;
    logic                  span_valid;
    logic                  span_stall = 1'b0;
    logic [COORD_BITS-1:0] row_y;
    logic [COORD_BITS-1:0] span_x_first;
    logic [COORD_BITS-1:0] span_x_final;
    logic [ADDR_W-1:0]     span_word_address;
    logic [COLOR_W-1:0]    span_color;
    logic                  span_empty;
    logic                  nothing_drawn;
    logic                  last_span;

    // local copy of the screen registers, reset values
    int screen_w = 1920;
    int screen_h = 1080;
    int pitch    = 1920;

    t_circle circles_pending[$];   // circles waiting to be sent
    t_span   spans_due[$];         // spans predicted but not yet seen
    t_circle held_circle;          // circle currently on the input port
    bit      circle_taken = 1'b0;  // input transaction at the last rising edge
    bit      calm = 1'b0;          // no idling on either side while set
    int      mismatches = 0;
    int      cycle_count = 0;

    filled_circle_span_rasterizer_top #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .i_valid             (circle_valid),
        .o_stall             (circle_stall),
        .i_center_x          (center_x),
        .i_center_y          (center_y),
        .i_radius            (radius),
        .i_fill_color        (fill_color),
        .o_valid             (span_valid),
        .i_stall             (span_stall),
        .o_row_y             (row_y),
        .o_span_x_first      (span_x_first),
        .o_span_x_final      (span_x_final),
        .o_span_word_address (span_word_address),
        .o_span_color        (span_color),
        .o_span_empty        (span_empty),
        .o_nothing_drawn     (nothing_drawn),
        .o_last_span         (last_span)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // largest k with k*k not above v
    function automatic int floor_root(int v);
        int k;
        k = 0;
        while ((k + 1) * (k + 1) <= v)
            k++;
        return k;
    endfunction

    // spans one circle produces with the current screen setup, in row order
    task automatic predict_spans(t_circle c);
        int    cx, cy, r, w, h, dy, row, half, first, last;
        bit    have_span;
        t_span s;
        t_span held;
        cx = $signed(c.cx);
        cy = $signed(c.cy);
        r  = c.radius;
        if (r > MAX_RADIUS)
            r = MAX_RADIUS;
        w = (screen_w > DIM_LIMIT) ? DIM_LIMIT : screen_w;
        h = (screen_h > DIM_LIMIT) ? DIM_LIMIT : screen_h;
        have_span = 1'b0;
        held = '0;
        for (dy = -r; dy <= r; dy++) begin
            row = cy + dy;
            if (row < 0 || row >= h)
                continue;
            half  = floor_root(r * r - dy * dy);
            first = cx - half;
            last  = cx + half;
            if (first < 0)
                first = 0;
            if (last > w - 1)
                last = w - 1;
            s = '0;
            // clipped away entirely: columns read as zero
            if (first > last) begin
                s.empty = 1'b1;
                first = 0;
                last  = 0;
            end
            s.row_y   = row[COORD_BITS-1:0];
            s.x_first = first[COORD_BITS-1:0];
            s.x_final = last[COORD_BITS-1:0];
            s.addr    = ADDR_W'(row * pitch + first);  // wraps at the address width
            s.color   = c.color;
            if (have_span)
                spans_due.push_back(held);
            held = s;
            have_span = 1'b1;
        end
        if (have_span) begin
            held.last = 1'b1;
            spans_due.push_back(held);
        end else begin
            // no row on screen: a single marker result
            s = '0;
            s.color = c.color;
            s.none  = 1'b1;
            s.last  = 1'b1;
            spans_due.push_back(s);
        end
    endtask

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        end
    endfunction

    // input side: record each transaction and predict its spans
    always @(posedge clk) begin
        circle_taken = circle_valid && !circle_stall;
        if (circle_taken)
            predict_spans(held_circle);
    end

    // driver: next circle once the held one is taken, random gaps and output stalls
    always @(negedge clk) begin
        if (rst_n && (!circle_valid || circle_taken)) begin
            if (circles_pending.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                held_circle = circles_pending.pop_front();
                circle_valid <= 1'b1;
                center_x     <= held_circle.cx;
                center_y     <= held_circle.cy;
                radius       <= held_circle.radius;
                fill_color   <= held_circle.color;
            end else begin
                circle_valid <= 1'b0;
            end
        end
        span_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    // monitor: each span transaction against the oldest prediction
    always @(posedge clk) begin : span_check
        t_span want;
        if (rst_n && span_valid === 1'b1 && span_stall === 1'b0) begin
            if (spans_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: span row %0h arrived with none expected", $time, row_y);
            end else begin
                want = spans_due.pop_front();
                check_field("row_y", want.row_y, row_y);
                check_field("span_x_first", want.x_first, span_x_first);
                check_field("span_x_final", want.x_final, span_x_final);
                check_field("span_word_address", want.addr, span_word_address);
                check_field("span_color", want.color, span_color);
                check_field("span_empty", want.empty, span_empty);
                check_field("nothing_drawn", want.none, nothing_drawn);
                check_field("last_span", want.last, last_span);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("filled_circle_span_rasterizer_top_test failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_reg idx, int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SCREEN_WIDTH:  screen_w = value[CFG_W-1:0];
            REG_SCREEN_HEIGHT: screen_h = value[CFG_W-1:0];
            REG_LINE_PITCH:    pitch    = value[CFG_W-1:0];
            default: ;
        endcase
    endtask

    // new screen setup, then line up with a rising edge before queueing circles
    task automatic set_screen(int w, int h, int p);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_LINE_PITCH, p);
        @(posedge clk);
    endtask

    task automatic add_circle(int x, int y, int r, logic [COLOR_W-1:0] color);
        t_circle c;
        c.cx     = x[IN_W-1:0];
        c.cy     = y[IN_W-1:0];
        c.radius = r[RAD_W-1:0];
        c.color  = color;
        circles_pending.push_back(c);
    endtask

    // mostly circles on or near the screen, the rest anywhere in range
    task automatic add_random(int count);
        int n, w, h, x, y;
        for (n = 0; n < count; n++) begin
            w = (screen_w > DIM_LIMIT) ? DIM_LIMIT : screen_w;
            h = (screen_h > DIM_LIMIT) ? DIM_LIMIT : screen_h;
            if ($urandom_range(99) < 70) begin
                x = $urandom_range(w + 80) - 40;
                y = $urandom_range(h + 80) - 40;
                if (x > 4095)
                    x = 4095;
                if (y > 4095)
                    y = 4095;
            end else begin
                x = $urandom_range(8191) - 4096;
                y = $urandom_range(8191) - 4096;
            end
            add_circle(x, y, $urandom_range(MAX_RADIUS), $urandom());
        end
    endtask

    // sender holds back until every predicted span has come out
    task automatic wait_idle();
        while (circles_pending.size() != 0 || circle_valid || spans_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset screen 1920 x 1080: corners, edges and clipping boundaries
        add_circle(960, 540, 0, 32'h0000_0000);     // single pixel
        add_circle(960, 540, 31, 32'hFFFF_FFFF);    // whole circle on screen
        add_circle(0, 0, 31, 32'hAAAA_AAAA);        // clipped left and top
        add_circle(1919, 1079, 31, 32'h5555_5555);  // clipped right and bottom
        add_circle(-4096, -4096, 31, 32'h1234_5678); // far off: nothing drawn
        add_circle(4095, 4095, 0, 32'h8765_4321);
        add_circle(4095, -4096, 31, 32'h0F0F_0F0F);
        add_circle(-4096, 500, 31, 32'hF0F0_F0F0);   // rows visible, every span empty
        add_circle(4095, 500, 17, 32'hDEAD_BEEF);
        add_circle(-31, 100, 31, 32'h0000_0001);     // one pixel left at column zero
        add_circle(-32, 100, 31, 32'h8000_0000);     // just off the left edge
        add_circle(1950, 200, 31, 32'h0000_FFFF);    // one pixel at the last column
        add_circle(1951, 200, 31, 32'hFFFF_0000);    // just off the right edge
        add_circle(300, -31, 31, 32'h0101_0101);     // only the top row
        add_circle(300, -32, 31, 32'h1010_1010);
        add_circle(300, 1110, 31, 32'h2020_2020);    // only the bottom row
        add_circle(300, 1111, 31, 32'h0202_0202);
        add_circle(-1, -1, 1, 32'hCAFE_F00D);
        wait_idle();

        // all registers at their top value: dimensions clamp, address wraps
        set_screen(8191, 8191, 8191);
        add_circle(4095, 4095, 31, 32'hA5A5_A5A5);
        add_circle(2048, 2048, 31, 32'h5A5A_5A5A);
        add_circle(0, 4095, 5, 32'h3C3C_3C3C);
        add_random(20);
        wait_idle();

        // zero width: any visible row is an empty span; single row screen
        set_screen(0, 1, 1);
        add_circle(0, 0, 31, 32'h7777_7777);
        add_circle(0, 0, 0, 32'h8888_8888);
        add_random(10);
        wait_idle();

        // zero height: nothing drawn whatever the circle
        set_screen(1, 0, 4096);
        add_circle(0, 0, 31, 32'h9999_9999);
        add_random(5);
        wait_idle();

        // largest exact screen, full speed on both sides
        calm = 1'b1;
        set_screen(4096, 4096, 1);
        add_random(30);
        wait_idle();
        calm = 1'b0;

        // tiny screens: clipping on most rows
        set_screen($urandom_range(1, 80), $urandom_range(1, 80), $urandom_range(1, 80));
        add_random(15);
        wait_idle();
        set_screen($urandom_range(1, 80), $urandom_range(1, 80), $urandom_range(1, 80));
        add_random(15);
        wait_idle();

        // anything the registers hold
        set_screen($urandom_range(8191), $urandom_range(8191), $urandom_range(8191));
        add_random(30);
        wait_idle();

        set_screen(640, 480, 1024);
        add_random(40);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && spans_due.size() == 0)
            $display("filled_circle_span_rasterizer_top_test passed");
        else
            $display("filled_circle_span_rasterizer_top_test failed");
        $finish;
    end

endmodule

[files.f]
src/fcsr_pkg.sv
src/filled_circle_span_rasterizer_top.sv
src/fcsr_checker.sv
test/filled_circle_span_rasterizer_top_test.sv
